FILE: design/ctpe_pkg.sv
package ctpe_pkg;

   localparam int POS_BITS      = 7;
   localparam int TRAVEL_BITS   = 20;
   localparam int TIME_BITS     = 32;
   localparam int CMD_BITS      = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [POS_BITS-1:0] POSITION_MAX = 7'd100;

   // motor commands
   localparam logic [CMD_BITS-1:0] CMD_NONE  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_STOP  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_OPEN  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLOSE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_OPENED_POS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLOSED_POS   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_OPEN_TRAVEL  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLOSE_TRAVEL = 2'd3;

   // shared multiply-divide unit: floor(a * b / d)
   localparam int MD_A_BITS = TIME_BITS;
   localparam int MD_B_BITS = POS_BITS;
   localparam int MD_P_BITS = MD_A_BITS + MD_B_BITS;
   localparam int MD_D_BITS = TIME_BITS;

   typedef struct packed {
      logic                 start;
      logic [MD_A_BITS-1:0] mul_a;
      logic [MD_B_BITS-1:0] mul_b;
      logic [MD_D_BITS-1:0] divisor;
   } md_req_type;

   typedef struct packed {
      logic                 done;
      logic [MD_P_BITS-1:0] quotient;
   } md_rsp_type;

   function automatic logic [POS_BITS-1:0] end_val(input logic [POS_BITS-1:0] r);
      end_val = (r > POSITION_MAX) ? POSITION_MAX : r;
   endfunction

   function automatic logic [CMD_BITS-1:0] dir_of(input logic [POS_BITS-1:0] op,
                                                  input logic [POS_BITS-1:0] cl,
                                                  input logic [POS_BITS-1:0] from,
                                                  input logic [POS_BITS-1:0] to);
      logic [CMD_BITS-1:0] d;
      d = CMD_NONE;
      if (op > cl) begin
         if (to > from) d = CMD_OPEN;
         else if (to < from) d = CMD_CLOSE;
      end else if (op < cl) begin
         if (to < from) d = CMD_OPEN;
         else if (to > from) d = CMD_CLOSE;
      end
      dir_of = d;
   endfunction

endpackage

FILE: design/ctpe_muldiv.sv
module ctpe_muldiv
   import ctpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type req,
   output md_rsp_type rsp
);

   localparam int CNT_BITS = $clog2(MD_P_BITS);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [MD_A_BITS-1:0] a_ff, a_in;
   logic [MD_B_BITS-1:0] b_ff, b_in;
   logic [MD_D_BITS-1:0] div_ff, div_in;
   logic [MD_D_BITS-1:0] rem_ff, rem_in;
   logic [MD_P_BITS-1:0] dvd_ff, dvd_in;

   logic [MD_P_BITS-1:0] prod;
   logic [MD_D_BITS:0]   rem_sh;
   logic [MD_D_BITS:0]   rem_diff;
   logic                 ge;

   assign prod = {{MD_B_BITS{1'b0}}, a_ff} * {{MD_A_BITS{1'b0}}, b_ff};

   // one restoring division step per cycle
   assign rem_sh   = {rem_ff, dvd_ff[MD_P_BITS-1]};
   assign ge       = rem_sh >= {1'b0, div_ff};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req.start) begin
               a_in     = req.mul_a;
               b_in     = req.mul_b;
               div_in   = req.divisor;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            dvd_in   = prod;
            rem_in   = '0;
            cnt_in   = '0;
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            rem_in = ge ? rem_diff[MD_D_BITS-1:0] : rem_sh[MD_D_BITS-1:0];
            dvd_in = {dvd_ff[MD_P_BITS-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(MD_P_BITS - 1)) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;

endmodule

FILE: design/cover_travel_position_estimator.sv
// Cover position estimator. One request transaction per tick carries the ms
// time, the two end switches and an optional target; one response transaction
// comes back with the motor command, estimated position and status flags.
// A tick that snaps to an end, stops, or starts a full-length move is answered
// straight from evaluation; a tick that plans a partial move or interpolates a
// running move waits for the shared multiply-divide unit (one operand
// multiply, then one quotient bit per cycle over a 39-bit dividend). A new
// request is taken only once the previous one has been handed to the response
// register. Configuration writes are always ready and must only be made while
// no tick is in flight.
module cover_travel_position_estimator
   import ctpe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // now_ms[31:0], closed_switch[32], opened_switch[33], target_valid[34],
   // target_position[41:35]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // motor_cmd[1:0], position[8:2], position_known[9], moving[10],
   // overrun_stop[11]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int POS_CALC_BITS = 18;
   localparam int QBIG_SHIFT    = 8;
   localparam int QBIG_BITS     = TIME_BITS + QBIG_SHIFT;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_PLAN   = 3'd2;
   localparam logic [2:0] S_INTERP = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;

   // captured transaction
   logic [TIME_BITS-1:0] now_ff;
   logic                 cs_ff, os_ff, tv_ff;
   logic [POS_BITS-1:0]  tgt_raw_ff;

   // configuration
   logic [POS_BITS-1:0]    opened_ff, closed_ff;
   logic [TRAVEL_BITS-1:0] open_travel_ff, close_travel_ff;

   // estimator state
   logic                 moving_ff, moving_in;
   logic [POS_BITS-1:0]  cur_pos_ff, cur_pos_in;
   logic                 known_ff, known_in;
   logic [POS_BITS-1:0]  start_pos_ff, start_pos_in;
   logic [TIME_BITS-1:0] start_time_ff, start_time_in;
   logic [TIME_BITS-1:0] end_time_ff, end_time_in;

   // per-tick work
   logic [CMD_BITS-1:0] cmd_ff, cmd_in;
   logic                ovr_ff, ovr_in;
   logic                qbig_ff, qbig_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   md_req_type md_req;
   md_rsp_type md_rsp;

   logic [POS_BITS-1:0]    op, cl, lo, hi, tgt, cur0, sw_cur, move_dist, mag, span;
   logic [POS_BITS-1:0]    out_pos, pos_final;
   logic                   sw_hit, sw_stop, full_travel;
   logic [CMD_BITS-1:0]    d_new;
   logic [TRAVEL_BITS-1:0] travel_new, travel_run;
   logic [TIME_BITS-1:0]   el, dur, over;
   logic                   ovr_now, qbig_now;
   logic [15:0]            off;
   logic signed [POS_CALC_BITS-1:0] pos_s, lo_s, hi_s, sp_s, off_s;

   always_comb begin
      op  = end_val(opened_ff);
      cl  = end_val(closed_ff);
      lo  = (op < cl) ? op : cl;
      hi  = (op < cl) ? cl : op;
      tgt = (tgt_raw_ff < lo) ? lo : ((tgt_raw_ff > hi) ? hi : tgt_raw_ff);
      cur0 = known_ff ? cur_pos_ff : cl;

      // end switches
      sw_hit  = cs_ff | os_ff;
      sw_cur  = cs_ff ? cl : (os_ff ? op : cur0);
      sw_stop = 1'b0;
      if (cs_ff)
         sw_stop = !(tv_ff && (dir_of(op, cl, cl, tgt) == CMD_OPEN));
      else if (os_ff)
         sw_stop = !(tv_ff && (dir_of(op, cl, op, tgt) == CMD_CLOSE));

      // move planning
      d_new       = dir_of(op, cl, sw_cur, tgt);
      travel_new  = (d_new == CMD_OPEN) ? open_travel_ff : close_travel_ff;
      full_travel = (tgt == op) || (tgt == cl) || (hi == lo);
      move_dist   = (tgt > sw_cur) ? (tgt - sw_cur) : (sw_cur - tgt);
      span        = hi - lo;

      // running move
      el         = now_ff - start_time_ff;
      dur        = end_time_ff - start_time_ff;
      over       = el - dur;
      mag        = (tgt > start_pos_ff) ? (tgt - start_pos_ff) : (start_pos_ff - tgt);
      travel_run = (dir_of(op, cl, start_pos_ff, tgt) == CMD_OPEN) ?
                   open_travel_ff : close_travel_ff;
      ovr_now    = (el > dur) && (over > {{(TIME_BITS-TRAVEL_BITS){1'b0}}, travel_run});
      // whole periods elapsed reach 256
      qbig_now   = {{QBIG_SHIFT{1'b0}}, el} >= {dur, {QBIG_SHIFT{1'b0}}};
   end

   // interpolation from the divider quotient
   always_comb begin
      off = qbig_ff ? 16'd256 : md_rsp.quotient[15:0];
      if (mag == '0) off = '0;
      off_s = $signed({{(POS_CALC_BITS-16){1'b0}}, off});
      sp_s  = $signed({{(POS_CALC_BITS-POS_BITS){1'b0}}, start_pos_ff});
      lo_s  = $signed({{(POS_CALC_BITS-POS_BITS){1'b0}}, lo});
      hi_s  = $signed({{(POS_CALC_BITS-POS_BITS){1'b0}}, hi});
      pos_s = (tgt < start_pos_ff) ? (sp_s - off_s) : (sp_s + off_s);
      if (pos_s < lo_s) pos_s = lo_s;
      if (pos_s > hi_s) pos_s = hi_s;
      pos_final = (dur == '0) ? tgt : pos_s[POS_BITS-1:0];
   end

   assign out_pos = known_ff ? cur_pos_ff : cl;

   always_comb begin
      state_in      = state_ff;
      moving_in     = moving_ff;
      cur_pos_in    = cur_pos_ff;
      known_in      = known_ff;
      start_pos_in  = start_pos_ff;
      start_time_in = start_time_ff;
      end_time_in   = end_time_ff;
      cmd_in        = cmd_ff;
      ovr_in        = ovr_ff;
      qbig_in       = qbig_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      md_req.start   = 1'b0;
      md_req.mul_a   = el;
      md_req.mul_b   = mag;
      md_req.divisor = dur;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EVAL;
         end
         S_EVAL: begin
            moving_in  = sw_stop ? 1'b0 : moving_ff;
            cmd_in     = sw_stop ? CMD_STOP : CMD_NONE;
            known_in   = sw_hit ? 1'b1 : known_ff;
            cur_pos_in = sw_hit ? sw_cur : cur_pos_ff;
            ovr_in     = 1'b0;
            qbig_in    = qbig_now;
            state_in   = S_DONE;
            if (tv_ff) begin
               if (tgt == sw_cur) begin
                  moving_in = 1'b0;
                  cmd_in    = CMD_STOP;
               end else if (!(sw_stop ? 1'b0 : moving_ff)) begin
                  start_pos_in = sw_cur;
                  if (d_new != CMD_NONE) begin
                     start_time_in = now_ff;
                     cmd_in        = d_new;
                     moving_in     = 1'b1;
                     if (full_travel) begin
                        end_time_in = now_ff +
                           {{(TIME_BITS-TRAVEL_BITS){1'b0}}, travel_new};
                     end else begin
                        md_req.start   = 1'b1;
                        md_req.mul_a   = {{(MD_A_BITS-TRAVEL_BITS){1'b0}}, travel_new};
                        md_req.mul_b   = move_dist;
                        md_req.divisor = {{(MD_D_BITS-POS_BITS){1'b0}}, span};
                        state_in       = S_PLAN;
                     end
                  end
               end else begin
                  md_req.start = 1'b1;
                  ovr_in       = ovr_now;
                  state_in     = S_INTERP;
               end
            end
         end
         S_PLAN: begin
            if (md_rsp.done) begin
               end_time_in = start_time_ff + md_rsp.quotient[TIME_BITS-1:0];
               state_in    = S_DONE;
            end
         end
         S_INTERP: begin
            if (md_rsp.done) begin
               known_in   = 1'b1;
               cur_pos_in = pos_final;
               if (ovr_ff) begin
                  cmd_in     = CMD_STOP;
                  moving_in  = 1'b0;
                  cur_pos_in = tgt;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, ovr_ff, moving_ff, known_ff, out_pos, cmd_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   ctpe_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         opened_ff       <= 7'd100;
         closed_ff       <= 7'd0;
         open_travel_ff  <= 20'd30000;
         close_travel_ff <= 20'd30000;
         moving_ff       <= 1'b0;
         cur_pos_ff      <= '0;
         known_ff        <= 1'b0;
         start_pos_ff    <= '0;
         start_time_ff   <= '0;
         end_time_ff     <= '0;
         cmd_ff          <= CMD_NONE;
         ovr_ff          <= 1'b0;
         qbig_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         moving_ff     <= moving_in;
         cur_pos_ff    <= cur_pos_in;
         known_ff      <= known_in;
         start_pos_ff  <= start_pos_in;
         start_time_ff <= start_time_in;
         end_time_ff   <= end_time_in;
         cmd_ff        <= cmd_in;
         ovr_ff        <= ovr_in;
         qbig_ff       <= qbig_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_OPENED_POS:   opened_ff       <= csr_data[POS_BITS-1:0];
               REG_CLOSED_POS:   closed_ff       <= csr_data[POS_BITS-1:0];
               REG_OPEN_TRAVEL:  open_travel_ff  <= csr_data;
               REG_CLOSE_TRAVEL: close_travel_ff <= csr_data;
               default: ;
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
      if (req_tvalid && req_tready) begin
         now_ff     <= req_tdata[31:0];
         cs_ff      <= req_tdata[32];
         os_ff      <= req_tdata[33];
         tv_ff      <= req_tdata[34];
         tgt_raw_ff <= req_tdata[41:35];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

FILE: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ctpe_pkg::*;

   // request fields, lowest bits last
   typedef struct packed {
      logic [POS_BITS-1:0]  target_position;
      logic                 target_valid;
      logic                 opened_switch;
      logic                 closed_switch;
      logic [TIME_BITS-1:0] now_ms;
   } tick_t;

   // response fields, lowest bits last
   typedef struct packed {
      logic                overrun_stop;
      logic                moving;
      logic                position_known;
      logic [POS_BITS-1:0] position;
      logic [CMD_BITS-1:0] motor_cmd;
   } estimate_t;

   typedef struct packed {
      logic  hold;
      tick_t tick;
   } queued_tick_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = REG_OPENED_POS;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   cover_travel_position_estimator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register copies
   logic [POS_BITS-1:0]    cfg_opened_pos = 7'd100;
   logic [POS_BITS-1:0]    cfg_closed_pos = 7'd0;
   logic [TRAVEL_BITS-1:0] cfg_open_ms    = 20'd30000;
   logic [TRAVEL_BITS-1:0] cfg_close_ms   = 20'd30000;

   // estimator state
   bit                   est_moving = 1'b0;
   int                   est_pos    = 0;
   bit                   est_known  = 1'b0;
   int                   move_from  = 0;
   logic [TIME_BITS-1:0] move_start = '0;
   logic [TIME_BITS-1:0] move_end   = '0;

   queued_tick_t pending_ticks[$];
   estimate_t    expected_estimates[$];
   logic [TIME_BITS-1:0] clock_ms = '0;

   int ticks_sent     = 0;
   int results_seen   = 0;
   int failures       = 0;
   int moves_started  = 0;
   int overrun_stops  = 0;
   int end_snaps      = 0;
   int settings_used  = 0;

   function automatic logic [CMD_BITS-1:0] heading(input int op, input int cl,
                                                   input int from, input int to);
      if (op > cl) return (to > from) ? CMD_OPEN : (to < from) ? CMD_CLOSE : CMD_NONE;
      if (op < cl) return (to < from) ? CMD_OPEN : (to > from) ? CMD_CLOSE : CMD_NONE;
      return CMD_NONE;
   endfunction

   function automatic int end_pos(input logic [POS_BITS-1:0] r);
      return (r > POSITION_MAX) ? int'(POSITION_MAX) : int'(r);
   endfunction

   // one tick of the estimator: updates state, returns the response it causes
   function automatic estimate_t advance_estimate(input tick_t t);
      int                   op, cl, lo, hi, tgt, cur;
      longint               pos, off;
      longint unsigned      el, dur, trav, mag, move_dist, span;
      logic [TIME_BITS-1:0] el_w, dur_w;
      logic [CMD_BITS-1:0]  cmd, way;
      logic                 ovr;
      estimate_t            e;
      op  = end_pos(cfg_opened_pos);
      cl  = end_pos(cfg_closed_pos);
      lo  = (op < cl) ? op : cl;
      hi  = (op < cl) ? cl : op;
      tgt = int'(t.target_position);
      if (tgt < lo) tgt = lo;
      if (tgt > hi) tgt = hi;
      cur = est_known ? est_pos : cl;
      cmd = CMD_NONE;
      ovr = 1'b0;

      // closed switch wins when both are active
      if (t.closed_switch) begin
         est_pos = cl;
         est_known = 1'b1;
         cur = cl;
         end_snaps++;
         if (!(t.target_valid && heading(op, cl, cur, tgt) == CMD_OPEN)) begin
            cmd = CMD_STOP;
            est_moving = 1'b0;
         end
      end else if (t.opened_switch) begin
         est_pos = op;
         est_known = 1'b1;
         cur = op;
         end_snaps++;
         if (!(t.target_valid && heading(op, cl, cur, tgt) == CMD_CLOSE)) begin
            cmd = CMD_STOP;
            est_moving = 1'b0;
         end
      end

      if (t.target_valid) begin
         if (tgt == cur) begin
            est_moving = 1'b0;
            cmd = CMD_STOP;
         end else if (!est_moving) begin
            way = heading(op, cl, cur, tgt);
            move_from = cur;
            if (way != CMD_NONE) begin
               trav = 64'((way == CMD_OPEN) ? cfg_open_ms : cfg_close_ms);
               span = 64'(hi - lo);
               move_dist = 64'((tgt > cur) ? tgt - cur : cur - tgt);
               // a move to an end always gets the full travel time
               if (tgt == op || tgt == cl || span == 0) dur = trav;
               else dur = trav * move_dist / span;
               move_start = t.now_ms;
               move_end = t.now_ms + dur[TIME_BITS-1:0];
               cmd = way;
               est_moving = 1'b1;
               moves_started++;
            end
         end else begin
            el_w = t.now_ms - move_start;
            dur_w = move_end - move_start;
            el = 64'(el_w);
            dur = 64'(dur_w);
            if (dur == 0) begin
               pos = longint'(tgt);
            end else begin
               mag = 64'((tgt > move_from) ? tgt - move_from : move_from - tgt);
               if (mag == 0) off = 0;
               else if (el / dur >= 256) off = 256;
               else off = longint'(mag * el / dur);
               pos = (tgt < move_from) ? longint'(move_from) - off
                                       : longint'(move_from) + off;
               if (pos < longint'(lo)) pos = longint'(lo);
               if (pos > longint'(hi)) pos = longint'(hi);
            end
            est_pos = int'(pos);
            est_known = 1'b1;
            trav = 64'((heading(op, cl, move_from, tgt) == CMD_OPEN) ? cfg_open_ms
                                                                     : cfg_close_ms);
            if (el > dur && el - dur > trav) begin
               cmd = CMD_STOP;
               est_moving = 1'b0;
               est_pos = tgt;
               ovr = 1'b1;
               overrun_stops++;
            end
         end
      end

      e.motor_cmd      = cmd;
      e.position       = POS_BITS'(est_known ? est_pos : cl);
      e.position_known = est_known;
      e.moving         = est_moving;
      e.overrun_stop   = ovr;
      return e;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_estimates.push_back(advance_estimate(tick_t'(req_tdata[$bits(tick_t)-1:0])));
            ticks_sent++;
         end
         if (pending_ticks.size() != 0
             && ((ticks_sent >= 200 && ticks_sent < 320) || $urandom_range(0, 99) >= 30)
             && !(pending_ticks[0].hold && expected_estimates.size() != 0)) begin
            req_tdata  <= REQ_DATA_BITS'(pending_ticks[0].tick);
            req_tvalid <= 1'b1;
            void'(pending_ticks.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      estimate_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = estimate_t'(rsp_tdata[$bits(estimate_t)-1:0]);
            results_seen++;
            if (expected_estimates.size() == 0) begin
               if (failures < 10)
                  $display("response %0d with no tick outstanding: cmd %0d pos %0d",
                           results_seen, got.motor_cmd, got.position);
               failures++;
            end else begin
               want = expected_estimates.pop_front();
               if (got.motor_cmd !== want.motor_cmd || got.position !== want.position
                   || got.position_known !== want.position_known
                   || got.moving !== want.moving
                   || got.overrun_stop !== want.overrun_stop) begin
                  if (failures < 10)
                     $display({"response %0d mismatch (expected/actual): cmd %0d/%0d ",
                               "pos %0d/%0d known %0b/%0b moving %0b/%0b overrun %0b/%0b"},
                              results_seen, want.motor_cmd, got.motor_cmd,
                              want.position, got.position,
                              want.position_known, got.position_known,
                              want.moving, got.moving, want.overrun_stop, got.overrun_stop);
                  failures++;
               end
            end
         end
         rsp_tready <= (results_seen >= 260 && results_seen < 380)
                       || $urandom_range(0, 99) >= 30;
      end
   end

   function automatic tick_t make_tick(input logic [TIME_BITS-1:0] now, input logic cs,
                                       input logic os, input logic tv,
                                       input logic [POS_BITS-1:0] tgt);
      tick_t t;
      t.now_ms          = now;
      t.closed_switch   = cs;
      t.opened_switch   = os;
      t.target_valid    = tv;
      t.target_position = tgt;
      return t;
   endfunction

   task automatic queue_tick(input logic hold, input tick_t t);
      queued_tick_t q;
      q.hold = hold;
      q.tick = t;
      pending_ticks.push_back(q);
   endtask

   task automatic put_reg(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input logic [CSR_DATA_BITS-1:0] opened,
                               input logic [CSR_DATA_BITS-1:0] closed,
                               input logic [CSR_DATA_BITS-1:0] open_ms,
                               input logic [CSR_DATA_BITS-1:0] close_ms);
      put_reg(REG_OPENED_POS, opened);
      put_reg(REG_CLOSED_POS, closed);
      put_reg(REG_OPEN_TRAVEL, open_ms);
      put_reg(REG_CLOSE_TRAVEL, close_ms);
      csr_valid <= 1'b0;
      cfg_opened_pos = opened[POS_BITS-1:0];
      cfg_closed_pos = closed[POS_BITS-1:0];
      cfg_open_ms    = open_ms;
      cfg_close_ms   = close_ms;
      settings_used++;
   endtask

   // let every queued tick finish, then the block's own latency
   task automatic drain();
      while (pending_ticks.size() != 0 || req_tvalid || expected_estimates.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   function automatic logic [POS_BITS-1:0] choose_aim(input int op, input int cl);
      if ($urandom_range(0, 2) == 0) return POS_BITS'(($urandom_range(0, 1) != 0) ? op : cl);
      return POS_BITS'($urandom_range(0, 100));
   endfunction

   // mostly move sequences toward a target, with switch hits, noise and idle ticks
   task automatic queue_random(input int count);
      int                  op, cl, made, steps, scale, k;
      logic [POS_BITS-1:0] aim;
      tick_t               t;
      op = end_pos(cfg_opened_pos);
      cl = end_pos(cfg_closed_pos);
      scale = int'((cfg_open_ms > cfg_close_ms) ? cfg_open_ms : cfg_close_ms);
      if (scale > 300000) scale = 300000;
      made = 0;
      while (made < count) begin
         k = $urandom_range(0, 9);
         if (k < 7) begin
            aim = choose_aim(op, cl);
            steps = $urandom_range(2, 10);
            for (int s = 0; s < steps; s++) begin
               if ($urandom_range(0, 6) == 0) aim = choose_aim(op, cl);
               clock_ms += $urandom_range(0, scale / 3 + 2);
               queue_tick(s == 0 && $urandom_range(0, 29) == 0,
                          make_tick(clock_ms, 1'b0, 1'b0, 1'b1, aim));
            end
            made += steps;
            // cover arrives at the end it was driven to
            if ($urandom_range(0, 1) != 0 && (aim == op || aim == cl)) begin
               clock_ms += $urandom_range(0, scale / 4 + 2);
               queue_tick(1'b0, make_tick(clock_ms, aim == cl, aim == op,
                                          1'($urandom_range(0, 1)), aim));
               made++;
            end
         end else if (k < 9) begin
            t = make_tick($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), POS_BITS'($urandom_range(0, 100)));
            if ($urandom_range(0, 3) == 0) clock_ms = t.now_ms;
            else t.now_ms = clock_ms + $urandom_range(0, 50);
            queue_tick(1'b0, t);
            made++;
         end else begin
            clock_ms += $urandom_range(0, scale / 5 + 2);
            queue_tick(1'b0, make_tick(clock_ms, $urandom_range(0, 7) == 0,
                                       $urandom_range(0, 7) == 0, 1'b0,
                                       POS_BITS'($urandom_range(0, 100))));
            made++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 0 closed, 100 open, 30 s each way
      queue_tick(1'b0, make_tick(32'd1000, 1'b0, 1'b0, 1'b0, 7'd0));
      queue_tick(1'b0, make_tick(32'd1010, 1'b0, 1'b0, 1'b1, 7'd0));
      queue_tick(1'b0, make_tick(32'd2000, 1'b0, 1'b0, 1'b1, 7'd100));
      queue_tick(1'b0, make_tick(32'd17000, 1'b0, 1'b0, 1'b1, 7'd100));
      queue_tick(1'b0, make_tick(32'd33000, 1'b0, 1'b0, 1'b1, 7'd100));
      queue_tick(1'b0, make_tick(32'd62001, 1'b0, 1'b0, 1'b1, 7'd100));
      queue_tick(1'b0, make_tick(32'd62100, 1'b0, 1'b1, 1'b1, 7'd0));
      queue_tick(1'b0, make_tick(32'd62200, 1'b1, 1'b1, 1'b0, 7'd0));
      queue_tick(1'b0, make_tick(32'd63000, 1'b0, 1'b0, 1'b1, 7'd37));
      queue_tick(1'b1, make_tick(32'd68550, 1'b0, 1'b0, 1'b1, 7'd37));
      queue_tick(1'b0, make_tick(32'd70000, 1'b0, 1'b0, 1'b1, 7'd80));
      queue_tick(1'b0, make_tick(32'd70100, 1'b0, 1'b0, 1'b0, 7'd0));
      queue_tick(1'b0, make_tick(32'd70200, 1'b1, 1'b0, 1'b1, 7'd60));
      queue_tick(1'b0, make_tick(32'hFFFF_FF00, 1'b0, 1'b1, 1'b1, 7'd0));
      queue_tick(1'b0, make_tick(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1, 7'd25));
      queue_tick(1'b0, make_tick(32'h0000_0F00, 1'b0, 1'b0, 1'b1, 7'd25));
      queue_tick(1'b0, make_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 7'd100));
      queue_tick(1'b0, make_tick(32'd0, 1'b0, 1'b1, 1'b1, 7'd100));
      queue_tick(1'b0, make_tick(32'd5, 1'b1, 1'b0, 1'b1, 7'd0));
      queue_tick(1'b0, make_tick(32'd6, 1'b0, 1'b0, 1'b1, 7'd64));
      drain();

      clock_ms = 32'd100;
      write_config(20'd100, 20'd0, 20'd500, 20'd700);
      queue_random(90);
      drain();
      // inverted ends
      write_config(20'd0, 20'd100, 20'd300, 20'd200);
      queue_random(90);
      drain();
      // zero and maximum travel times
      write_config(20'd80, 20'd20, 20'd0, 20'hFFFFF);
      queue_random(80);
      drain();
      // open end register above the range reads as the top
      write_config(20'hFFFFF, 20'd5, 20'd1, 20'd1000);
      queue_random(90);
      drain();
      // equal ends give no direction
      write_config(20'd50, 20'd50, 20'd400, 20'd400);
      queue_random(60);
      drain();
      write_config(20'd100, 20'd0, 20'hFFFFF, 20'd0);
      queue_random(80);
      drain();
      // moves straddling the time wrap
      clock_ms = 32'hFFFF_E000;
      write_config(20'd30, 20'd90, 20'd900, 20'd600);
      queue_random(90);
      drain();

      $display("%0d ticks checked across %0d register settings", results_seen, settings_used);
      $display("%0d moves planned, %0d overrun stops, %0d end switch hits",
               moves_started, overrun_stops, end_snaps);
      if (failures == 0 && expected_estimates.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
